>>> sv/amrq_pkg.sv
// Package for the ack matched retransmit queue: widths, entry and request types,
// controller/datapath command and status structs, index helpers.
// No dependencies.
`default_nettype none
package amrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_FRAME   = 1024;
  localparam int MIN_FRAME   = 16;

  localparam int IDX_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ACK_W    = 8;
  localparam int LEN_W    = 11;
  localparam int SENDER_W = 16;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 48;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef struct packed {
    logic [ACK_W-1:0]    ack;
    logic [LEN_W-1:0]    len;
    logic [SENDER_W-1:0] sender;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_WAIT,
    ST_SCAN,
    ST_SHIFT,
    ST_HEAD_RD,
    ST_HEAD_WAIT
  } state_t;

  typedef struct packed {
    logic cap;
    logic do_append;
    logic do_clear;
    logic rd_head;
    logic rd_pos;
    logic shift_wr;
    logic set_ok;
    logic dec_count;
    logic load_pop;
    logic load_head;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic empty;
    logic full;
    logic pos_end;
    logic match;
    logic out_free;
  } status_t;

  // base + off, wrapped into the ring; off never exceeds the depth
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] r;
    r = l;
    if (l < LEN_W'(MIN_FRAME)) begin
      r = LEN_W'(MIN_FRAME);
    end else if (l > LEN_W'(MAX_FRAME)) begin
      r = LEN_W'(MAX_FRAME);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/amrq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module amrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> sv/amrq_ctrl.sv
// Controller for the retransmit queue: sequences append, pop, clear, remove scan and
// compaction, and result loading. Depends on amrq_pkg.
`default_nettype none
module amrq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire amrq_pkg::status_t st,
  output amrq_pkg::cmd_t         cmd
);
  import amrq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (st.req)
          REQ_POP:    state_next = st.empty ? ST_HEAD_RD : ST_POP_WAIT;
          REQ_REMOVE: state_next = st.empty ? ST_HEAD_RD : ST_SCAN;
          default:    state_next = ST_HEAD_RD;
        endcase
      end
      ST_POP_WAIT: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (st.pos_end) begin
          state_next = ST_HEAD_RD;
        end else if (st.match) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (st.pos_end) state_next = ST_HEAD_RD;
      end
      ST_HEAD_RD: state_next = ST_HEAD_WAIT;
      ST_HEAD_WAIT: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.cap  = s_tvalid;
      end
      ST_EXEC: begin
        unique case (st.req)
          REQ_APPEND: cmd.do_append = !st.full;
          REQ_POP:    cmd.rd_head   = !st.empty;
          REQ_REMOVE: cmd.rd_pos    = !st.empty;
          default:    cmd.do_clear  = 1'b1;
        endcase
      end
      ST_POP_WAIT: cmd.load_pop = st.out_free;
      ST_SCAN: begin
        cmd.set_ok    = st.match;
        cmd.dec_count = st.match && st.pos_end;
        cmd.rd_pos    = !st.pos_end;
      end
      ST_SHIFT: begin
        cmd.shift_wr  = 1'b1;
        cmd.rd_pos    = !st.pos_end;
        cmd.dec_count = st.pos_end;
      end
      ST_HEAD_RD:   cmd.rd_head   = 1'b1;
      ST_HEAD_WAIT: cmd.load_head = st.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/amrq_dp.sv
// Datapath for the retransmit queue: request register, ring pointers, entry RAM,
// match compare and result register. Depends on amrq_pkg and amrq_ram.
`default_nettype none
module amrq_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [amrq_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire logic [amrq_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [amrq_pkg::M_TDATA_W-1:0] m_tdata,
  input  wire amrq_pkg::cmd_t                 cmd,
  output amrq_pkg::status_t                   st
);
  import amrq_pkg::*;

  req_t                req;
  logic [ACK_W-1:0]    in_ack;
  logic [LEN_W-1:0]    in_len;
  logic [SENDER_W-1:0] in_sender;
  logic [ACK_W-1:0]    want;

  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos;
  logic             ok;

  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  entry_t           ram_wr_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  entry_t           rd_data;

  logic                res_ok;
  entry_t              res_entry;
  logic [CNT_W-1:0]    res_count;
  logic                res_empty;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req       <= req_t'(s_tuser[1:0]);
      in_ack    <= s_tdata[7:0];
      in_len    <= s_tdata[18:8];
      in_sender <= s_tdata[34:19];
      want      <= s_tdata[42:35];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      pos   <= '0;
      ok    <= 1'b0;
    end else begin
      if (cmd.cap) begin
        pos <= '0;
        ok  <= 1'b0;
      end else if (cmd.rd_pos) begin
        pos <= pos + CNT_W'(1);
      end
      if (cmd.do_append || cmd.do_clear || cmd.set_ok) begin
        ok <= 1'b1;
      end
      if (cmd.do_append) begin
        count <= count + CNT_W'(1);
      end else if (cmd.do_clear) begin
        count <= '0;
      end else if (cmd.dec_count || cmd.load_pop) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.load_pop) begin
        head <= wrap_idx(head, CNT_W'(1));
      end
    end
  end

  assign ram_wr_en   = cmd.do_append || cmd.shift_wr;
  assign ram_wr_addr = cmd.do_append ? wrap_idx(head, count)
                                     : wrap_idx(head, pos - CNT_W'(2));
  assign ram_wr_data = cmd.do_append ? entry_t'{in_ack, clamp_len(in_len), in_sender}
                                     : rd_data;
  assign ram_rd_en   = cmd.rd_head || cmd.rd_pos;
  assign ram_rd_addr = cmd.rd_pos ? wrap_idx(head, pos) : head;

  amrq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_pop || cmd.load_head) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pop) begin
      res_ok    <= 1'b1;
      res_entry <= rd_data;
      res_count <= count - CNT_W'(1);
      res_empty <= (count == CNT_W'(1));
    end else if (cmd.load_head) begin
      res_ok    <= ok;
      res_entry <= (count != '0) ? rd_data : '0;
      res_count <= count;
      res_empty <= (count == '0);
    end
  end

  assign m_tdata = {6'd0, res_empty, res_count, res_entry.sender, res_entry.len,
                    res_entry.ack, res_ok};

  assign st.req      = req;
  assign st.empty    = (count == '0);
  assign st.full     = (count == CNT_W'(QUEUE_DEPTH));
  assign st.pos_end  = (pos == count);
  assign st.match    = (rd_data.ack == want);
  assign st.out_free = !m_tvalid || m_tready;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_pos |-> pos < count)
    else $error("scan read past the last entry");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load_pop |-> count != '0)
    else $error("pop from an empty queue");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> pos >= CNT_W'(2))
    else $error("compaction write before the match slot");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    cmd.load_head |=> res_count == $past(count))
    else $error("reported count differs from held count");
`endif

endmodule
`default_nettype wire

>>> sv/ack_matched_retransmit_queue_unit.sv
// Ack matched retransmit queue: ring of 16 descriptors in one RAM, one transfer
// in gives one transfer out. Pop reads the head and registers it as the result;
// append and clear change the queue, failed pop does not; all then read the head;
// remove first scans and compacts (scan and compaction go one RAM read per cycle).
// The next item is taken the cycle after the result is registered, not before.
// Synchronous active-high reset empties the queue; entries are not cleared.
`default_nettype none
module ack_matched_retransmit_queue_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // ack_id[7:0], frame_len[18:8], sender_id[34:19], match_ack[42:35], zero fill
  input  wire logic [amrq_pkg::S_TDATA_W-1:0] s_tdata,
  // req_type[1:0]
  input  wire logic [amrq_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // ok[0], got_ack[8:1], got_len[19:9], got_sender[35:20], entry_count[40:36],
  // is_empty[41], zero fill
  output logic      [amrq_pkg::M_TDATA_W-1:0] m_tdata
);
  import amrq_pkg::*;

  cmd_t    cmd;
  status_t st;

  amrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  amrq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .st       (st)
  );

endmodule
`default_nettype wire
